// ===== src/tcc_pkg.sv =====
// tcc_pkg: shared types and codes for the text console cursor controller
// holds command, result, character and register codes, register reset values, and the result, cursor and step structs
// no dependencies
package tcc_pkg;

    // command codes of an input transaction
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;

    // result op codes
    localparam logic [1:0] OP_GLYPH  = 2'd0;
    localparam logic [1:0] OP_SCROLL = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;

    // register map, index into the word-aligned address space
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_FG   = 2'd2;
    localparam logic [1:0] REG_BG   = 2'd3;

    // reset values of the registers
    localparam logic [7:0]  COLS_RST = 8'd80;
    localparam logic [7:0]  ROWS_RST = 8'd25;
    localparam logic [31:0] FG_RST   = 32'h00FF_FFFF;
    localparam logic [31:0] BG_RST   = 32'h0000_0000;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
    } t_cursor;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  glyph;
        logic [31:0] fg;
        logic [31:0] bg;
    } t_res;

    // everything one command produces
    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
        t_cursor    cursor;
    } t_step;

endpackage

// ===== src/tcc_step.sv =====
// tcc_step: combinational cursor update for one command
// gives up to two results and the next cursor position
// depends on tcc_pkg
module tcc_step (
    input  tcc_pkg::t_cursor i_cursor,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_char_code,
    input  logic [7:0]       i_target_col,
    input  logic [7:0]       i_target_row,
    input  logic [7:0]       i_column_count,
    input  logic [7:0]       i_row_count,
    input  logic [31:0]      i_fg,
    input  logic [31:0]      i_bg,
    output tcc_pkg::t_step   o_step
);
    import tcc_pkg::*;

    // one step right, wrapping onto the next line
    function automatic t_cursor f_advance(input t_cursor c, input logic [7:0] cc);
        t_cursor n;
        begin
            n = c;
            if (({1'b0, c.col} + 9'd1) < {1'b0, cc}) begin
                n.col = c.col + 8'd1;
            end else begin
                n.col = 8'd0;
                n.row = c.row + 8'd1;
            end
            return n;
        end
    endfunction

    // one step left, onto the end of the line above; holds at home
    function automatic t_cursor f_back(input t_cursor c, input logic [7:0] cc);
        t_cursor n;
        begin
            n = c;
            if (c.col != 8'd0) begin
                n.col = c.col - 8'd1;
            end else if (c.row != 8'd0) begin
                n.col = cc - 8'd1;
                n.row = c.row - 8'd1;
            end
            return n;
        end
    endfunction

    t_cursor    cur;
    t_cursor    draw_pos;
    logic [7:0] draw_glyph;
    logic       has_scroll;
    logic       has_draw;
    logic       is_clear;
    t_cursor    nxt;
    t_res       scroll_res;
    t_res       clear_res;
    t_res       draw_res;

    // command decode and cursor walk
    always_comb begin
        cur        = i_cursor;
        nxt        = i_cursor;
        draw_pos   = '0;
        draw_glyph = '0;
        has_scroll = 1'b0;
        has_draw   = 1'b0;
        is_clear   = 1'b0;
        unique case (i_command)
            CMD_PUT: begin
                if (cur.row == i_row_count) begin
                    has_scroll = 1'b1;
                    cur.row    = cur.row - 8'd1;
                end
                if (i_char_code >= CH_SPACE && i_char_code <= CH_TILDE) begin
                    has_draw   = 1'b1;
                    draw_pos   = cur;
                    draw_glyph = i_char_code;
                    cur        = f_advance(cur, i_column_count);
                end else begin
                    case (i_char_code)
                        CH_NL: begin
                            cur.row = cur.row + 8'd1;
                            cur.col = 8'd0;
                        end
                        CH_TAB: begin
                            cur = f_advance(cur, i_column_count);
                            cur = f_advance(cur, i_column_count);
                            cur = f_advance(cur, i_column_count);
                        end
                        CH_CR: begin
                            cur.col = 8'd0;
                        end
                        CH_BS: begin
                            // back up, blank the cell, then net one step back
                            cur = f_back(cur, i_column_count);
                            if (cur.row == i_row_count) begin
                                has_scroll = 1'b1;
                                cur.row    = cur.row - 8'd1;
                            end
                            has_draw   = 1'b1;
                            draw_pos   = cur;
                            draw_glyph = CH_SPACE;
                            cur        = f_advance(cur, i_column_count);
                            cur        = f_back(cur, i_column_count);
                        end
                        default: begin
                        end
                    endcase
                end
                nxt = cur;
            end
            CMD_CLEAR: begin
                is_clear = 1'b1;
                nxt      = '0;
            end
            CMD_MOVE: begin
                nxt.col = i_target_col;
                nxt.row = i_target_row;
            end
            default: begin
            end
        endcase
    end

    // result words; a scroll always comes before the glyph draw
    always_comb begin
        scroll_res    = '0;
        scroll_res.op = OP_SCROLL;
        clear_res     = '0;
        clear_res.op  = OP_CLEAR;
        draw_res.op    = OP_GLYPH;
        draw_res.col   = draw_pos.col;
        draw_res.row   = draw_pos.row;
        draw_res.glyph = draw_glyph;
        draw_res.fg    = i_fg;
        draw_res.bg    = i_bg;

        o_step.cursor = nxt;
        o_step.res1   = draw_res;
        if (is_clear) begin
            o_step.count = 2'd1;
            o_step.res0  = clear_res;
        end else begin
            o_step.count = {1'b0, has_scroll} + {1'b0, has_draw};
            o_step.res0  = has_scroll ? scroll_res : draw_res;
        end
    end

endmodule

// ===== src/text_console_cursor_control.sv =====
// text_console_cursor_control: top level of the text console cursor engine
// input register, step logic, two-slot result register and register port
// depends on tcc_pkg and tcc_step
//
//  channel   direction  handshake            payload
//  command   in         i_valid / o_stall    i_command, i_char_code, i_target_col/row
//  result    out        o_valid / i_stall    o_op, o_cell_col/row, o_glyph_code,
//                                            o_fg_out, o_bg_out, o_last
//  config    in         psel/penable/pready  paddr, pwdata, prdata
//
// a command is registered in the input register, worked out by the combinational step logic and its
// results land in the result register once that register is free
// one command a cycle while each gives at most one result and the result side does not stall; a command with two
// results holds the result register for two transactions
// o_stall rises when the registered command cannot move into a full result register
// synchronous reset homes the cursor and loads the register defaults
module text_console_cursor_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_target_col,
    input  logic [7:0]  i_target_row,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_op,
    output logic [7:0]  o_cell_col,
    output logic [7:0]  o_cell_row,
    output logic [7:0]  o_glyph_code,
    output logic [31:0] o_fg_out,
    output logic [31:0] o_bg_out,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcc_pkg::*;

    logic [7:0]  r_cols;
    logic [7:0]  r_rows;
    logic [31:0] r_fg;
    logic [31:0] r_bg;
    logic        cfg_wr;

    t_cursor     r_cursor;

    logic        r_iv;
    logic        n_iv;
    logic [1:0]  r_cmd;
    logic [7:0]  r_char;
    logic [7:0]  r_tcol;
    logic [7:0]  r_trow;

    logic        r_ov;
    logic        r_o_sel;
    logic        r_o_two;
    t_res        r_res0;
    t_res        r_res1;
    t_res        show;

    t_step       step;
    logic        in_acc;
    logic        out_acc;
    logic        out_free;
    logic        s1_go;
    logic        load_out;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
            r_fg   <= FG_RST;
            r_bg   <= BG_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COLS: r_cols <= pwdata[7:0];
                REG_ROWS: r_rows <= pwdata[7:0];
                REG_FG:   r_fg   <= pwdata;
                REG_BG:   r_bg   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COLS: prdata = {24'd0, r_cols};
            REG_ROWS: prdata = {24'd0, r_rows};
            REG_FG:   prdata = r_fg;
            REG_BG:   prdata = r_bg;
            default:  prdata = '0;
        endcase
    end

    // step logic on the registered command
    tcc_step u_step (
        .i_cursor       (r_cursor),
        .i_command      (r_cmd),
        .i_char_code    (r_char),
        .i_target_col   (r_tcol),
        .i_target_row   (r_trow),
        .i_column_count (r_cols),
        .i_row_count    (r_rows),
        .i_fg           (r_fg),
        .i_bg           (r_bg),
        .o_step         (step)
    );

    // flow control between the stages
    assign out_acc  = r_ov && !i_stall;
    assign out_free = !r_ov || (out_acc && (r_o_sel || !r_o_two));
    assign s1_go    = r_iv && ((step.count == 2'd0) || out_free);
    assign load_out = s1_go && (step.count != 2'd0);
    assign o_stall  = r_iv && !s1_go;
    assign in_acc   = i_valid && !o_stall;
    assign n_iv     = in_acc || (r_iv && !s1_go);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else begin
            r_iv <= n_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_command;
            r_char <= i_char_code;
            r_tcol <= i_target_col;
            r_trow <= i_target_row;
        end
    end

    // cursor moves when the command leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (s1_go) begin
            r_cursor <= step.cursor;
        end
    end

    // result register control, second slot shown after the first is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_o_sel <= 1'b0;
            r_o_two <= 1'b0;
        end else if (load_out) begin
            r_ov    <= 1'b1;
            r_o_sel <= 1'b0;
            r_o_two <= (step.count == 2'd2);
        end else if (out_acc) begin
            if (!r_o_sel && r_o_two) begin
                r_o_sel <= 1'b1;
            end else begin
                r_ov    <= 1'b0;
                r_o_sel <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res0 <= step.res0;
            r_res1 <= step.res1;
        end
    end

    // result outputs
    assign show         = r_o_sel ? r_res1 : r_res0;
    assign o_valid      = r_ov;
    assign o_op         = show.op;
    assign o_cell_col   = show.col;
    assign o_cell_row   = show.row;
    assign o_glyph_code = show.glyph;
    assign o_fg_out     = show.fg;
    assign o_bg_out     = show.bg;
    assign o_last       = r_o_sel || !r_o_two;

    // second slot is only ever shown for a two-result command
    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_sel) |-> (r_o_two && o_last))
        else $error("second result slot shown without a second result");

    // cursor only moves when a command leaves the input register
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_go |=> $stable(r_cursor))
        else $error("cursor changed without a command");

    // once the first result of a pair is taken, the pending second result is never dropped
    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !r_o_sel && r_o_two) |=> (r_ov && r_o_sel))
        else $error("second result of a pair lost");

    // nothing is loaded over a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result register overwritten");

endmodule

// ===== tb/sv/text_console_cursor_control_tb.sv =====
// text_console_cursor_control_tb: self-checking testbench for the text console cursor engine
// drives commands and the register port, predicts draw, scroll and clear results in a scoreboard
// depends on tcc_pkg and text_console_cursor_control
module text_console_cursor_control_tb;
    import tcc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_PER_CMD     = 2;
    localparam int DRAIN_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 242;
    localparam int MAX_SHOWN       = 100;

    // one predicted result together with its end-of-command flag
    typedef struct packed {
        t_res res;
        logic last;
    } t_cell_write;

    // cursor predictor and queue of pending results
    class console_scoreboard;
        logic [7:0]  cur_col;
        logic [7:0]  cur_row;
        logic [7:0]  cols;
        logic [7:0]  rows;
        logic [31:0] fg;
        logic [31:0] bg;
        t_cell_write step_q[$];
        t_cell_write expected_q[$];
        int n_fail;
        int n_commands;
        int n_results;
        int n_glyph;
        int n_scroll;
        int n_clear;

        function new();
            cur_col    = '0;
            cur_row    = '0;
            cols       = COLS_RST;
            rows       = ROWS_RST;
            fg         = FG_RST;
            bg         = BG_RST;
            n_fail     = 0;
            n_commands = 0;
            n_results  = 0;
            n_glyph    = 0;
            n_scroll   = 0;
            n_clear    = 0;
        endfunction

        function void report(string msg);
            if (n_fail < MAX_SHOWN)
                $display("error at %0t: %s", $realtime, msg);
            else if (n_fail == MAX_SHOWN)
                $display("further errors counted but not shown");
            n_fail++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_COLS: cols = val[7:0];
                REG_ROWS: rows = val[7:0];
                REG_FG:   fg   = val;
                default:  bg   = val;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_COLS: return {24'd0, cols};
                REG_ROWS: return {24'd0, rows};
                REG_FG:   return fg;
                default:  return bg;
            endcase
        endfunction

        // a command gives two results at most, further ones are dropped
        function void queue_result(logic [1:0] op, logic draw, logic [7:0] code);
            t_cell_write e;
            if (step_q.size() >= MAX_PER_CMD)
                return;
            e.res.op    = op;
            e.res.col   = draw ? cur_col : 8'd0;
            e.res.row   = draw ? cur_row : 8'd0;
            e.res.glyph = draw ? code : 8'd0;
            e.res.fg    = draw ? fg : 32'd0;
            e.res.bg    = draw ? bg : 32'd0;
            e.last      = 1'b0;
            step_q.push_back(e);
        endfunction

        // step right, wrapping onto the next line at the column count
        function void advance();
            if (int'(cur_col) + 1 < int'(cols)) begin
                cur_col = cur_col + 8'd1;
            end else begin
                cur_col = 8'd0;
                cur_row = cur_row + 8'd1;
            end
        endfunction

        // step left, onto the end of the line above, holding at home
        function void back_up();
            if (cur_col != 8'd0) begin
                cur_col = cur_col - 8'd1;
            end else if (cur_row != 8'd0) begin
                cur_col = cols - 8'd1;
                cur_row = cur_row - 8'd1;
            end
        endfunction

        // only a row exactly at the row count scrolls
        function void scroll_check();
            if (cur_row == rows) begin
                queue_result(OP_SCROLL, 1'b0, 8'd0);
                cur_row = cur_row - 8'd1;
            end
        endfunction

        function void draw_here(logic [7:0] code);
            queue_result(OP_GLYPH, 1'b1, code);
            advance();
        endfunction

        // accepted command transaction: update cursor, queue its results
        function void note_command(logic [1:0] cmd, logic [7:0] ch, logic [7:0] tcol,
                                   logic [7:0] trow);
            step_q.delete();
            n_commands++;
            case (cmd)
                CMD_PUT: begin
                    scroll_check();
                    if (ch >= CH_SPACE && ch <= CH_TILDE) begin
                        draw_here(ch);
                    end else if (ch == CH_NL) begin
                        cur_row = cur_row + 8'd1;
                        cur_col = 8'd0;
                    end else if (ch == CH_TAB) begin
                        advance();
                        advance();
                        advance();
                    end else if (ch == CH_CR) begin
                        cur_col = 8'd0;
                    end else if (ch == CH_BS) begin
                        back_up();
                        scroll_check();
                        draw_here(CH_SPACE);
                        back_up();
                    end
                end
                CMD_CLEAR: begin
                    queue_result(OP_CLEAR, 1'b0, 8'd0);
                    cur_col = 8'd0;
                    cur_row = 8'd0;
                end
                CMD_MOVE: begin
                    cur_col = tcol;
                    cur_row = trow;
                end
                default: ;
            endcase
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        function void compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                                 n_results, name, got, want));
        endfunction

        // accepted result transaction against the oldest prediction
        function void check_result(t_res got, logic got_last);
            t_cell_write want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with none pending: op %0d col %0d row %0d",
                                 got.op, got.col, got.row));
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            case (want.res.op)
                OP_GLYPH:  n_glyph++;
                OP_SCROLL: n_scroll++;
                default:   n_clear++;
            endcase
            compare_field("op", 32'(got.op), 32'(want.res.op));
            compare_field("cell_col", 32'(got.col), 32'(want.res.col));
            compare_field("cell_row", 32'(got.row), 32'(want.res.row));
            compare_field("glyph_code", 32'(got.glyph), 32'(want.res.glyph));
            compare_field("fg_out", got.fg, want.res.fg);
            compare_field("bg_out", got.bg, want.res.bg);
            compare_field("last", 32'(got_last), 32'(want.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [7:0]  i_char_code;
    logic [7:0]  i_target_col;
    logic [7:0]  i_target_row;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_op;
    logic [7:0]  o_cell_col;
    logic [7:0]  o_cell_row;
    logic [7:0]  o_glyph_code;
    logic [31:0] o_fg_out;
    logic [31:0] o_bg_out;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    console_scoreboard sb = new();
    logic no_idle = 1'b0;
    int   quiet_cycles = 0;

    text_console_cursor_control dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_target_col (i_target_col),
        .i_target_row (i_target_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_op         (o_op),
        .o_cell_col   (o_cell_col),
        .o_cell_row   (o_cell_row),
        .o_glyph_code (o_glyph_code),
        .o_fg_out     (o_fg_out),
        .o_bg_out     (o_bg_out),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // monitor: both channels and the register port, plus quiet-cycle count
    always @(posedge i_clk) begin
        t_res seen;
        if (i_rst_n) begin
            seen.op    = o_op;
            seen.col   = o_cell_col;
            seen.row   = o_cell_row;
            seen.glyph = o_glyph_code;
            seen.fg    = o_fg_out;
            seen.bg    = o_bg_out;
            if (i_valid && !o_stall)
                sb.note_command(i_command, i_char_code, i_target_col, i_target_row);
            if (o_valid && !i_stall)
                sb.check_result(seen, o_last);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge i_clk);
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stall before each result transaction
    initial begin
        int wait_n;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            wait_n = no_idle ? 0 : $urandom_range(0, 7);
            if (wait_n > 0) begin
                i_stall = 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // one command transaction, after a random gap
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [7:0] tcol, input logic [7:0] trow);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_command    = cmd;
        i_char_code  = ch;
        i_target_col = tcol;
        i_target_row = trow;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_command(CMD_PUT, ch, 8'($urandom), 8'($urandom));
    endtask

    task automatic move_to(input logic [7:0] tcol, input logic [7:0] trow);
        send_command(CMD_MOVE, 8'($urandom), tcol, trow);
    endtask

    // register port: setup then access, finishing on pready
    task automatic reg_access(input logic write, input logic [1:0] idx,
                              input logic [31:0] val, output logic [31:0] rd);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        reg_access(1'b1, idx, val, rd);
        sb.set_reg(idx, val);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (idx == REG_FG || idx == REG_BG) ? 32'hFFFF_FFFF : 32'h0000_00FF;
        reg_access(1'b0, idx, $urandom, rd);
        if ((rd & mask) !== sb.reg_value(idx))
            sb.report($sformatf("register %0d reads 0x%0h, predicted 0x%0h",
                                idx, rd, sb.reg_value(idx)));
    endtask

    // let every pending result drain, then allow for commands still in flight
    task automatic wait_idle();
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [7:0]  new_cols;
        logic [7:0]  new_rows;
        logic [7:0]  ch;
        logic [7:0]  tcol;
        logic [7:0]  trow;
        logic [1:0]  cmd;
        int pick;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = CMD_PUT;
        i_char_code  = '0;
        i_target_col = '0;
        i_target_row = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of the registers
        check_reg(REG_COLS);
        check_reg(REG_ROWS);
        check_reg(REG_FG);
        check_reg(REG_BG);

        // directed: character classes and cursor corners at the default geometry
        put_char(8'd65);
        put_char(CH_SPACE);
        put_char(CH_TILDE);
        put_char(8'd31);
        put_char(8'd127);
        put_char(8'd255);
        put_char(8'd0);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_NL);
        // printable at the last column wraps to the next line
        move_to(COLS_RST - 8'd1, 8'd0);
        put_char(8'd122);
        // tab running off the end of a line
        move_to(COLS_RST - 8'd2, 8'd3);
        put_char(CH_TAB);
        // cursor sitting on the row count scrolls before drawing
        move_to(8'd0, ROWS_RST);
        put_char(8'd120);
        // backspace from column 0 one row past the count scrolls on its second check
        move_to(8'd0, ROWS_RST + 8'd1);
        put_char(CH_BS);
        // backspace at home holds at home
        move_to(8'd0, 8'd0);
        put_char(CH_BS);
        // backspace at column 0 goes to the end of the line above
        move_to(8'd0, 8'd5);
        put_char(CH_BS);
        send_command(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        send_command(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
        move_to(8'd255, 8'd255);
        put_char(8'd33);

        // random phases, each under its own register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(REG_COLS, 32'd4);
                    write_reg(REG_ROWS, 32'd2);
                    write_reg(REG_FG, 32'hFFFF_FFFF);
                    write_reg(REG_BG, 32'h0000_0000);
                end
                1: begin
                    write_reg(REG_COLS, 32'd255);
                    write_reg(REG_ROWS, 32'd255);
                    write_reg(REG_FG, 32'h0000_0000);
                    write_reg(REG_BG, 32'hFFFF_FFFF);
                end
                default: begin
                    new_cols = $urandom_range(0, 1) ? 8'($urandom_range(4, 16))
                                                    : 8'($urandom_range(4, 255));
                    new_rows = $urandom_range(0, 1) ? 8'($urandom_range(2, 8))
                                                    : 8'($urandom_range(2, 255));
                    write_reg(REG_COLS, {24'd0, new_cols});
                    write_reg(REG_ROWS, {24'd0, new_rows});
                    write_reg(REG_FG, $urandom);
                    write_reg(REG_BG, $urandom);
                end
            endcase
            check_reg(REG_COLS);
            check_reg(REG_ROWS);
            check_reg(REG_FG);
            check_reg(REG_BG);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // a stretch of back-to-back traffic in every phase
                no_idle = (k >= 100 && k < 150);
                cmd  = CMD_PUT;
                ch   = 8'($urandom);
                tcol = 8'($urandom);
                trow = 8'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    ch = 8'($urandom_range(CH_SPACE, CH_TILDE));
                end else if (pick < 58) begin
                    ch = CH_NL;
                end else if (pick < 63) begin
                    ch = CH_TAB;
                end else if (pick < 67) begin
                    ch = CH_CR;
                end else if (pick < 75) begin
                    ch = CH_BS;
                end else if (pick < 80) begin
                    ch = 8'($urandom);
                end else if (pick < 94) begin
                    // moves mostly land near the bottom and the line ends
                    cmd = CMD_MOVE;
                    case ($urandom_range(0, 4))
                        0: tcol = 8'd0;
                        1: tcol = sb.cols - 8'd1;
                        2: tcol = sb.cols - 8'd2;
                        3: tcol = 8'($urandom_range(0, sb.cols - 1));
                        default: ;
                    endcase
                    case ($urandom_range(0, 4))
                        0: trow = sb.rows;
                        1: trow = sb.rows - 8'd1;
                        2: trow = sb.rows + 8'd1;
                        3: trow = 8'($urandom_range(0, sb.rows));
                        default: ;
                    endcase
                end else if (pick < 98) begin
                    cmd = CMD_CLEAR;
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_command(cmd, ch, tcol, trow);
            end
            no_idle = 1'b0;
        end

        // drain and finish
        wait_idle();
        $display("run: %0d commands over %0d register settings", sb.n_commands,
                 RANDOM_PHASES + 1);
        $display("results checked: %0d glyph writes, %0d scrolls, %0d clears, %0d errors",
                 sb.n_glyph, sb.n_scroll, sb.n_clear, sb.n_fail);
        if (sb.n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/tcc_pkg.sv
src/tcc_step.sv
src/text_console_cursor_control.sv
tb/sv/text_console_cursor_control_tb.sv
